### rtl/tscw_pkg.sv
// Shared constants, codes and controller/datapath interface types for the text screen writer.
package tscw_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 64;
  localparam int TAB_SPACES = 4;
  localparam int MEM_CELLS  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(MEM_CELLS);

  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 6;
  localparam int CROW_W     = 7;
  localparam int WID_W      = 8;
  localparam int HGT_W      = 7;
  localparam int FUNC_W     = 2;
  localparam int CFG_AW     = 1;
  localparam int TAB_CNT_W  = $clog2(TAB_SPACES + 1);
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [WID_W-1:0]  WIDTH_RESET  = 8'd80;
  localparam logic [HGT_W-1:0]  HEIGHT_RESET = 7'd25;

  localparam logic [CHAR_W-1:0] CODE_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

  localparam logic [CFG_AW-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NUL,
    KIND_NL,
    KIND_TAB,
    KIND_PRINT
  } kind_e;

  typedef struct packed {
    logic load;
    logic put_step;
    logic move;
    logic sweep_step;
    logic sweep_full;
    logic home;
    logic rd_issue;
    logic out_load;
  } tscw_cmd_t;

  typedef struct packed {
    op_e   in_op;
    kind_e in_kind;
    logic  step_drop;
    logic  step_wrap;
    logic  sweep_last;
    logic  out_free;
  } tscw_sts_t;

  function automatic kind_e char_kind(logic [CHAR_W-1:0] c);
    kind_e k;
    if (c == CODE_NUL) k = KIND_NUL;
    else if (c == CODE_NL) k = KIND_NL;
    else if (c == CODE_TAB) k = KIND_TAB;
    else k = KIND_PRINT;
    return k;
  endfunction

endpackage

### rtl/tscw_ctrl.sv
// Operation sequencer for the text screen writer: init sweep, put/fill loops, move, clear, read.
module tscw_ctrl import tscw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  tscw_sts_t sts_i,
  output tscw_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_NOP,
    S_MOVE,
    S_CHR,
    S_NL,
    S_TAB,
    S_CLR,
    S_RD,
    S_RDF,
    S_HOLD
  } state_e;

  state_e               state_q, state_d;
  logic [TAB_CNT_W-1:0] tab_cnt_q, tab_cnt_d;
  logic                 finish;

  always_comb begin
    state_d    = state_q;
    tab_cnt_d  = tab_cnt_q;
    cmd_o      = '0;
    finish     = 1'b0;
    s_tready_o = (state_q == S_IDLE);
    case (state_q)
      S_INIT: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_full = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          tab_cnt_d  = '0;
          case (sts_i.in_op)
            OP_PUT: begin
              case (sts_i.in_kind)
                KIND_NUL: state_d = S_NOP;
                KIND_NL:  state_d = S_NL;
                KIND_TAB: state_d = S_TAB;
                default:  state_d = S_CHR;
              endcase
            end
            OP_MOVE:  state_d = S_MOVE;
            OP_CLEAR: state_d = S_CLR;
            default:  state_d = S_RD;
          endcase
        end
      end
      S_NOP: finish = 1'b1;
      S_MOVE: begin
        cmd_o.move = 1'b1;
        finish     = 1'b1;
      end
      S_CHR: begin
        cmd_o.put_step = 1'b1;
        finish         = 1'b1;
      end
      S_NL: begin
        // blank to end of row; the wrapping write moves to the next row
        cmd_o.put_step = 1'b1;
        if (sts_i.step_drop || sts_i.step_wrap) finish = 1'b1;
      end
      S_TAB: begin
        cmd_o.put_step = 1'b1;
        if (sts_i.step_drop || tab_cnt_q == TAB_CNT_W'(TAB_SPACES - 1)) begin
          finish = 1'b1;
        end else begin
          tab_cnt_d = tab_cnt_q + TAB_CNT_W'(1);
        end
      end
      S_CLR: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.home = 1'b1;
          finish     = 1'b1;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RDF;
      end
      S_RDF: finish = 1'b1;
      S_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (finish) begin
      if (sts_i.out_free) begin
        cmd_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end else begin
        state_d = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      tab_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      tab_cnt_q <= tab_cnt_d;
    end
  end

endmodule

### rtl/tscw_dp.sv
// Datapath: screen memory, cursor, size registers, address calc, sweep counter, result register.
module tscw_dp import tscw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tscw_cmd_t             cmd_i,
  output tscw_sts_t             sts_o,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic [FUNC_W-1:0]     s_tuser_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_AW-1:0]     cfg_addr_i,
  input  logic [WID_W-1:0]      cfg_data_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  localparam int PROD_W = ROW_W + WID_W;

  logic [CHAR_W-1:0] mem [MEM_CELLS];

  logic [WID_W-1:0]  width_q;
  logic [HGT_W-1:0]  height_q;
  logic [WID_W-1:0]  eff_w;
  logic [CROW_W-1:0] eff_h;

  op_e               func_q;
  logic [CHAR_W-1:0] code_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;

  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [CROW_W-1:0] cur_row_q, cur_row_d;
  logic              drop_q, drop_d;

  logic [ADDR_W-1:0] cnt_q, clr_last_q;
  logic [PROD_W-1:0] area;

  logic [CROW_W-1:0] row_sat, n_row;
  logic [COL_W-1:0]  n_col;
  logic              col_over;
  logic [WID_W-1:0]  col_inc;
  logic [WID_W-1:0]  col_lim;
  logic [CROW_W-1:0] mv_row;

  logic [ROW_W-1:0]  mul_row;
  logic [COL_W-1:0]  mul_col;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] addr;

  logic              mem_we;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wdata, put_val;
  logic [CHAR_W-1:0] rd_q, cell_val;
  logic              rd_ok_q;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // active size, held to 1..max
  always_comb begin
    if (width_q == '0) eff_w = WID_W'(1);
    else if (width_q > WID_W'(MAX_COLS)) eff_w = WID_W'(MAX_COLS);
    else eff_w = width_q;
    if (height_q == '0) eff_h = CROW_W'(1);
    else if (height_q > CROW_W'(MAX_ROWS)) eff_h = CROW_W'(MAX_ROWS);
    else eff_h = height_q;
  end

  // cursor brought back into range before each put (no change once in range)
  always_comb begin
    row_sat   = (cur_row_q > eff_h) ? eff_h : cur_row_q;
    col_over  = ({1'b0, cur_col_q} >= eff_w);
    n_col     = col_over ? '0 : cur_col_q;
    n_row     = (col_over && row_sat < eff_h) ? row_sat + CROW_W'(1) : row_sat;
    col_inc   = {1'b0, n_col} + WID_W'(1);
    col_lim   = eff_w - WID_W'(1);
    mv_row    = ({1'b0, row_q} > eff_h) ? eff_h : {1'b0, row_q};
  end

  // linear cell address row*W + col, shared by put and read
  always_comb begin
    mul_row = cmd_i.rd_issue ? row_q : n_row[ROW_W-1:0];
    mul_col = cmd_i.rd_issue ? col_q : n_col;
    prod    = PROD_W'(mul_row) * PROD_W'(eff_w) + PROD_W'(mul_col);
    addr    = prod[ADDR_W-1:0];
    area    = PROD_W'(eff_w) * PROD_W'(eff_h) - PROD_W'(1);
  end

  always_comb begin
    put_val = (code_q == CODE_NL || code_q == CODE_TAB) ? CODE_SPACE : code_q;
    mem_we  = (cmd_i.put_step && !(n_row >= eff_h)) || cmd_i.sweep_step;
    waddr   = cmd_i.sweep_step ? cnt_q : addr;
    wdata   = cmd_i.sweep_step ? CODE_SPACE : put_val;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd_i.rd_issue) rd_q <= mem[addr];
  end

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    drop_d    = drop_q;
    if (cmd_i.load) drop_d = 1'b0;
    if (cmd_i.put_step) begin
      if (n_row >= eff_h) begin
        cur_col_d = n_col;
        cur_row_d = n_row;
        drop_d    = 1'b1;
      end else if (col_inc >= eff_w) begin
        cur_col_d = '0;
        cur_row_d = n_row + CROW_W'(1);
      end else begin
        cur_col_d = col_inc[COL_W-1:0];
        cur_row_d = n_row;
      end
    end
    if (cmd_i.move) begin
      cur_col_d = ({1'b0, col_q} > col_lim) ? col_lim[COL_W-1:0] : col_q;
      cur_row_d = mv_row;
    end
    if (cmd_i.home) begin
      cur_col_d = '0;
      cur_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      drop_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_addr_i == CFG_WIDTH) width_q <= cfg_data_i;
        else height_q <= cfg_data_i[HGT_W-1:0];
      end
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      drop_q    <= drop_d;
      if (cmd_i.load) cnt_q <= '0;
      else if (cmd_i.sweep_step) cnt_q <= cnt_q + ADDR_W'(1);
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q     <= op_e'(s_tuser_i);
      code_q     <= s_tdata_i[CHAR_W-1:0];
      col_q      <= s_tdata_i[CHAR_W +: COL_W];
      row_q      <= s_tdata_i[CHAR_W+COL_W +: ROW_W];
      clr_last_q <= area[ADDR_W-1:0];
    end
    if (cmd_i.rd_issue) begin
      rd_ok_q <= ({1'b0, col_q} < eff_w) && ({1'b0, row_q} < eff_h);
    end
    if (cmd_i.out_load) begin
      out_data_q <= {1'b0, drop_d, cur_row_d, cur_col_d, cell_val};
    end
  end

  assign cell_val = (func_q == OP_READ && rd_ok_q) ? rd_q : CODE_NUL;

  always_comb begin
    sts_o.in_op      = op_e'(s_tuser_i);
    sts_o.in_kind    = char_kind(s_tdata_i[CHAR_W-1:0]);
    sts_o.step_drop  = (n_row >= eff_h);
    sts_o.step_wrap  = (col_inc >= eff_w);
    sts_o.sweep_last = cmd_i.sweep_full ? (cnt_q == ADDR_W'(MEM_CELLS - 1))
                                        : (cnt_q == clr_last_q);
    sts_o.out_free   = !out_valid_q || m_tready_i;
  end

  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o  = out_valid_q;
  assign m_tdata_o   = out_data_q;

endmodule

### rtl/text_screen_char_writer.sv
// Top level of the text screen character writer: sequencer plus datapath.
// One operation per input transfer, one result transfer per operation. After reset
// the block blanks all 8192 cells of its screen memory, one cell a cycle, and holds
// s_axis_tready low until that sweep ends; size registers may be written meanwhile.
// Work per item after acceptance: a printable character writes one cell; code 0 and move
// cursor write none; read cell reads one; tab writes 4 spaces (fewer once writes fall
// below the last row); newline blanks to the row end; clear blanks width * height cells.
// The fill loops write one cell per cycle through the single memory write port. A
// finished result sits in the output register; the next item is taken once that
// result is loaded, and the block stalls only while a new result finds it still full.
module text_screen_char_writer import tscw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // s_axis_tdata: char_code[7:0], col[14:8], row[20:15], zero pad[23:21]
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // s_axis_tuser: func[1:0]
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_AW-1:0]     cfg_addr_i,
  input  logic [WID_W-1:0]      cfg_data_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // m_axis_tdata: cell_char[7:0], cursor_col[14:8], cursor_row[21:15],
  //               off_screen[22], zero pad[23]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  tscw_cmd_t cmd;
  tscw_sts_t sts;

  tscw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tscw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

### rtl/tscw_checker.sv
// Port-level checks for the text screen writer, bound to the top level.
module tscw_checker import tscw_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // memory blanking runs first after reset
  a_init_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !s_axis_tready)
    else $error("input taken during reset blanking");

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  // cursor row never passes the largest height
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[21:15] <= 7'(MAX_ROWS))
    else $error("cursor row out of range");

  // a dropped write means the cursor sits past a screen of at least one row
  a_drop_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[22] |-> m_axis_tdata[21:15] != 7'd0)
    else $error("off_screen with cursor on row zero");

endmodule

bind text_screen_char_writer tscw_checker u_tscw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/tb_text_screen_char_writer.sv
// Self-checking testbench for text_screen_char_writer: random streams against a shadow screen.
module tb_text_screen_char_writer import tscw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    op_e               func;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } screen_op_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_chr;
    logic [COL_W-1:0]  ccol;
    logic [CROW_W-1:0] crow;
    logic              off;
  } cursor_report_t;

  localparam int PHASES        = 12;
  localparam int PHASE_OPS     = 130;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_REPORTS   = 200;
  localparam int SMALL_AREA    = 1024;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]     s_axis_tuser = '0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_AW-1:0]     cfg_addr_i = '0;
  logic [WID_W-1:0]      cfg_data_i = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  text_screen_char_writer i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  // Shadow copy of the screen, cursor and size registers
  logic [CHAR_W-1:0] shadow_cells [MEM_CELLS];
  int unsigned       cur_x = 0;
  int unsigned       cur_y = 0;
  logic [WID_W-1:0]  width_reg = WIDTH_RESET;
  logic [HGT_W-1:0]  height_reg = HEIGHT_RESET;

  screen_op_t     pending_ops_q [$];
  cursor_report_t expected_reports_q [$];
  screen_op_t     op_in_flight;

  int source_idle_pct = 28;
  int sink_idle_pct   = 28;
  int error_count     = 0;
  int reports_checked = 0;
  int drops_seen      = 0;
  int settings_used   = 1;
  int ops_by_kind [4] = '{default: 0};

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Generous bound: clearing pass, every op's fill loop and random stalls, many times over
  initial begin
    #12_000_000;
    $display("tb_text_screen_char_writer: errors");
    $finish;
  end

  function automatic int unsigned eff_cols();
    int unsigned w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    return w;
  endfunction

  function automatic int unsigned eff_rows();
    int unsigned h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  function automatic void poke(int unsigned x, int unsigned y, logic [CHAR_W-1:0] v);
    int unsigned a;
    a = y * eff_cols() + x;
    if (a < MEM_CELLS) shadow_cells[a] = v;
  endfunction

  function automatic void line_feed();
    cur_x = 0;
    if (cur_y < eff_rows()) cur_y++;
  endfunction

  // One cell at the cursor; returns 1 when the write falls below the last row
  function automatic logic place_cell(logic [CHAR_W-1:0] v);
    if (cur_y >= eff_rows()) return 1'b1;
    poke(cur_x, cur_y, v);
    cur_x++;
    if (cur_x >= eff_cols()) line_feed();
    return 1'b0;
  endfunction

  function automatic cursor_report_t predict_screen_op(screen_op_t op);
    cursor_report_t rep;
    int unsigned    w;
    int unsigned    h;
    int unsigned    n;
    logic           dropped;
    w = eff_cols();
    h = eff_rows();
    dropped = 1'b0;
    rep.cell_chr = '0;
    case (op.func)
      OP_PUT: begin
        if (op.code != CODE_NUL) begin
          // a cursor left stale by a size change is pulled back first
          if (cur_y > h) cur_y = h;
          if (cur_x >= w) line_feed();
          if (op.code == CODE_NL) begin
            if (cur_y >= h) begin
              dropped = 1'b1;
            end else begin
              for (int unsigned i = cur_x; i < w; i++) poke(i, cur_y, CODE_SPACE);
              line_feed();
            end
          end else if (op.code == CODE_TAB) begin
            repeat (TAB_SPACES) if (place_cell(CODE_SPACE)) dropped = 1'b1;
          end else begin
            dropped = place_cell(op.code);
          end
        end
      end
      OP_MOVE: begin
        cur_x = (op.col > w - 1) ? w - 1 : op.col;
        cur_y = (op.row > h) ? h : op.row;
      end
      OP_CLEAR: begin
        n = w * h;
        for (int unsigned i = 0; i < n && i < MEM_CELLS; i++) shadow_cells[i] = CODE_SPACE;
        cur_x = 0;
        cur_y = 0;
      end
      default: begin
        if (op.col < w && op.row < h) rep.cell_chr = shadow_cells[op.row * w + op.col];
      end
    endcase
    rep.ccol = cur_x[COL_W-1:0];
    rep.crow = cur_y[CROW_W-1:0];
    rep.off  = dropped;
    return rep;
  endfunction

  function automatic void queue_op(op_e f, logic [CHAR_W-1:0] c, logic [COL_W-1:0] x,
                                   logic [ROW_W-1:0] y);
    screen_op_t op;
    op.func = f;
    op.code = c;
    op.col  = x;
    op.row  = y;
    pending_ops_q.push_back(op);
  endfunction

  // Mostly text with cursor moves and reads aimed at the active area; some noise
  function automatic screen_op_t random_screen_op();
    screen_op_t  op;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    w = eff_cols();
    h = eff_rows();
    op.func = OP_PUT;
    op.code = CHAR_W'($urandom);
    op.col  = COL_W'($urandom);
    op.row  = ROW_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) begin
      case ($urandom_range(15))
        0, 1: op.code = CODE_NL;
        2, 3: op.code = CODE_TAB;
        4: op.code = CODE_NUL;
        default: ;
      endcase
    end else if (pick < 90) begin
      op.func = (pick < 62) ? OP_MOVE : OP_READ;
      if ($urandom_range(4) != 0) begin
        op.col = COL_W'($urandom_range(w > 127 ? 127 : w));
        op.row = ROW_W'($urandom_range(h > 63 ? 63 : h));
      end
    end else if (pick < 93) begin
      op.func = OP_CLEAR;
      // big clears cost a cycle per cell, keep them rare
      if (w * h > SMALL_AREA && $urandom_range(9) != 0) op.func = OP_READ;
    end else begin
      op.func = op_e'($urandom_range(3));
      if (op.func == OP_CLEAR && w * h > SMALL_AREA) op.func = OP_READ;
    end
    return op;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      error_count++;
      if (error_count <= MAX_REPORTS) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : op_driver
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reports_q.push_back(predict_screen_op(op_in_flight));
        ops_by_kind[op_in_flight.func]++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops_q.size() != 0 && $urandom_range(99) >= source_idle_pct) begin
          op_in_flight = pending_ops_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, op_in_flight.row, op_in_flight.col, op_in_flight.code};
          s_axis_tuser  <= op_in_flight.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    cursor_report_t want;
    cursor_report_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cell_chr = m_axis_tdata[7:0];
        got.ccol     = m_axis_tdata[14:8];
        got.crow     = m_axis_tdata[21:15];
        got.off      = m_axis_tdata[22];
        if (expected_reports_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $error("result transfer with nothing outstanding: tdata 0x%h", m_axis_tdata);
        end else begin
          want = expected_reports_q.pop_front();
          reports_checked++;
          if (want.off) drops_seen++;
          check_field("cell_char", want.cell_chr, got.cell_chr);
          check_field("cursor_col", want.ccol, got.ccol);
          check_field("cursor_row", want.crow, got.crow);
          check_field("off_screen", want.off, got.off);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic write_size_reg(input logic [CFG_AW-1:0] idx, input logic [WID_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_WIDTH) width_reg = value;
    else height_reg = value[HGT_W-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops_q.size() != 0 || s_axis_tvalid || expected_reports_q.size() != 0);
  endtask

  initial begin : stimulus
    logic [WID_W-1:0] widths  [PHASES];
    logic [WID_W-1:0] heights [PHASES];
    widths  = '{8'd8, 8'd1, 8'd128, 8'd255, 8'd0, 8'd80, 8'd40, 8'd3, 8'd100, 8'd17,
                8'd64, 8'd0};
    // bit 7 of the height writes is ignored by the block but still toggled here
    heights = '{8'd4, 8'd1, 8'd64, 8'hFF, 8'd0, 8'd25, 8'h8C, 8'd2, 8'd50, 8'd9,
                8'hA0, 8'd0};
    widths[PHASES-1]  = WID_W'($urandom_range(255));
    heights[PHASES-1] = WID_W'($urandom_range(255));
    for (int i = 0; i < MEM_CELLS; i++) shadow_cells[i] = CODE_SPACE;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass at the reset size of 80 x 25
    queue_op(OP_READ, 8'h00, 7'd0, 6'd0);
    queue_op(OP_PUT, 8'h41, 7'd0, 6'd0);
    queue_op(OP_PUT, 8'hFF, 7'h7F, 6'h3F);
    queue_op(OP_PUT, 8'h01, 7'd0, 6'd0);
    queue_op(OP_PUT, CODE_NUL, 7'd0, 6'd0);
    queue_op(OP_PUT, CODE_TAB, 7'd0, 6'd0);
    queue_op(OP_PUT, CODE_NL, 7'd0, 6'd0);
    queue_op(OP_READ, 8'h00, 7'd1, 6'd0);
    // past the screen: writes dropped, cursor parked at row H
    queue_op(OP_MOVE, 8'h00, 7'd127, 6'd63);
    queue_op(OP_PUT, 8'h42, 7'd0, 6'd0);
    queue_op(OP_PUT, CODE_TAB, 7'd0, 6'd0);
    queue_op(OP_PUT, CODE_NL, 7'd0, 6'd0);
    queue_op(OP_PUT, CODE_NUL, 7'd0, 6'd0);
    // tab from the second-last cell runs off the bottom halfway through
    queue_op(OP_MOVE, 8'h00, 7'd78, 6'd24);
    queue_op(OP_PUT, CODE_TAB, 7'd0, 6'd0);
    queue_op(OP_READ, 8'h00, 7'd79, 6'd24);
    queue_op(OP_READ, 8'h00, 7'd0, 6'd0);
    queue_op(OP_READ, 8'h00, 7'd127, 6'd63);
    queue_op(OP_READ, 8'h00, 7'd80, 6'd0);
    queue_op(OP_MOVE, 8'h00, 7'd5, 6'd3);
    queue_op(OP_PUT, 8'h7E, 7'd0, 6'd0);
    queue_op(OP_CLEAR, 8'h00, 7'd0, 6'd0);
    queue_op(OP_READ, 8'h00, 7'd5, 6'd3);
    // leaves a column beyond the next, narrower width
    queue_op(OP_MOVE, 8'h00, 7'd79, 6'd2);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_size_reg(CFG_WIDTH, widths[p]);
      write_size_reg(CFG_HEIGHT, heights[p]);
      settings_used++;
      source_idle_pct = (widths[p] == 8'd80) ? 0 : 28;
      sink_idle_pct   = source_idle_pct;
      for (int k = 0; k < PHASE_OPS; k++) pending_ops_q.push_back(random_screen_op());
      // random final move so the next size change may leave a stale cursor
      queue_op(OP_MOVE, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d puts, %0d moves, %0d clears and %0d reads over %0d screen sizes.",
             ops_by_kind[OP_PUT], ops_by_kind[OP_MOVE], ops_by_kind[OP_CLEAR],
             ops_by_kind[OP_READ], settings_used);
    $display("%0d results compared, %0d of them with a dropped write.", reports_checked,
             drops_seen);
    if (error_count == 0 && expected_reports_q.size() == 0) begin
      $display("tb_text_screen_char_writer: clean");
    end else begin
      $display("tb_text_screen_char_writer: errors");
    end
    $finish;
  end

endmodule
